// File: src/gsm_pkg.sv
`default_nettype none
package gsm_pkg;

   // fixed-point constants, Q.32 positions and values, Q.60 inside exp
   localparam logic [63:0] GOLD_Q32  = 64'd2654435769;
   localparam logic [63:0] LN2_Q60   = 64'h0B17217F7D1CF79B;
   localparam logic [63:0] ONE_Q60   = 64'h1000000000000000;
   localparam logic [66:0] K_BIAS    = 67'd13 * {3'b000, LN2_Q60};
   localparam logic signed [4:0] K_START = -5'sd13;
   localparam logic [4:0]  EXP_TERMS = 5'd20;
   localparam logic signed [37:0] POS_LIMIT = 38'sd34359738368;
   localparam logic signed [48:0] VAL_LIMIT = 49'sd17592186044416;
   localparam logic [32:0] THR_RESET = 33'd17;

   typedef enum logic [1:0] {
      SH_GOLD,
      SH_TAYLOR,
      SH_SQUARE
   } shift_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      shift_type   sh;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } mul_rsp_type;

   typedef struct packed {
      logic               done;
      logic signed [45:0] value;
   } obj_rsp_type;

   typedef enum logic [2:0] {
      C_IDLE,
      C_LONG,
      C_SHORT,
      C_EVAL_RIGHT,
      C_EVAL_LEFT,
      C_STEP_MUL,
      C_STEP_EVAL,
      C_DONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      O_IDLE,
      O_REDUCE,
      O_TERM_MUL,
      O_TERM_DIV,
      O_SCALE,
      O_SQUARE
   } obj_state_type;

   function automatic logic signed [37:0] clamp_pos(input logic signed [37:0] v);
      logic signed [37:0] r;
      r = v;
      if (v > POS_LIMIT) begin
         r = POS_LIMIT;
      end else if (v < -POS_LIMIT) begin
         r = -POS_LIMIT;
      end
      return r;
   endfunction

   function automatic logic [63:0] mag38(input logic signed [37:0] v);
      logic [37:0] m;
      m = v[37] ? 38'(-v) : 38'(v);
      return {26'b0, m};
   endfunction

endpackage
`default_nettype wire

// File: src/golden_section_minimizer.sv
`default_nettype none
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | req_tdata: interval_low, interval_high
// rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: bracket ends, inner points, values
// csr     | in  | csr_wr_en              | csr_wr_data: stop_threshold
//
// One transaction at a time; req_tready is high only while idle.
// Work per transaction: each objective evaluation is a range reduction, then 20 Taylor
// terms, each a multiply on the shared 32x32 unit plus a divide; each golden step adds
// a golden multiply on the same unit; up to MAX_STEPS+1 evaluations per transaction.
// Reset (synchronous) returns to idle, empties the output register, threshold = 17.
// A finished result sits in the output register; the next request is taken while
// it waits, and a new result waits in the final state until the register frees.
module golden_section_minimizer #(
   parameter int MAX_STEPS = 51
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic [32:0]   csr_wr_data,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // [36:0] interval_low, [73:37] interval_high, [79:74] zero
   input  wire logic [79:0]   req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [36:0] bracket_left, [73:37] inner_left, [110:74] inner_right,
   // [147:111] bracket_right, [193:148] value_left, [239:194] value_right
   output logic [239:0]       rsp_tdata
);

   localparam int CW = $clog2(MAX_STEPS);

   gsm_pkg::ctrl_state_type state_ff, state_in;
   logic signed [37:0] left_ff, left_in, right_ff, right_in;
   logic signed [37:0] il_ff, il_in, ir_ff, ir_in;
   logic signed [37:0] long_ff, long_in, short_ff, short_in;
   logic signed [45:0] vl_ff, vl_in, vr_ff, vr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               launched_ff, launched_in;
   logic               take_left_ff, take_left_in;
   logic [32:0]        thr_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [239:0]       rsp_data_ff, rsp_data_in;

   gsm_pkg::mul_req_type top_req, obj_req, mul_req;
   gsm_pkg::mul_rsp_type mul_rsp;
   gsm_pkg::obj_rsp_type obj_rsp;
   logic               obj_start, obj_busy;
   logic signed [37:0] obj_x;
   logic signed [37:0] gold_len, gold_val, gold_mag;
   logic signed [37:0] new_short;
   logic               stop_now;

   // one multiplier for the golden steps and the objective alike
   assign mul_req = obj_busy ? obj_req : top_req;

   gsm_mulshr u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   gsm_obj u_obj (
      .clock   (clock),
      .reset   (reset),
      .start   (obj_start),
      .x       (obj_x),
      .busy    (obj_busy),
      .rsp     (obj_rsp),
      .mul_req (obj_req),
      .mul_rsp (mul_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsm_pkg::C_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= gsm_pkg::THR_RESET;
         count_ff     <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         il_ff        <= '0;
         ir_ff        <= '0;
         long_ff      <= '0;
         short_ff     <= '0;
         vl_ff        <= '0;
         vr_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         il_ff        <= il_in;
         ir_ff        <= ir_in;
         long_ff      <= long_in;
         short_ff     <= short_in;
         vl_ff        <= vl_in;
         vr_ff        <= vr_in;
      end
      take_left_ff <= take_left_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      il_in        = il_ff;
      ir_in        = ir_ff;
      long_in      = long_ff;
      short_in     = short_ff;
      vl_in        = vl_ff;
      vr_in        = vr_ff;
      count_in     = count_ff;
      launched_in  = launched_ff;
      take_left_in = take_left_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      obj_start    = 1'b0;
      obj_x        = left_ff + long_ff;
      top_req      = '0;
      top_req.sh   = gsm_pkg::SH_GOLD;
      top_req.b    = gsm_pkg::GOLD_Q32;

      // length times 1/phi (about 0.618), rounded on the magnitude
      case (state_ff)
         gsm_pkg::C_LONG:  gold_len = right_ff - left_ff;
         gsm_pkg::C_SHORT: gold_len = long_ff;
         default:          gold_len = short_ff;
      endcase
      top_req.a = gsm_pkg::mag38(gold_len);
      gold_mag  = $signed(mul_rsp.result[37:0]);
      gold_val  = gold_len[37] ? -gold_mag : gold_mag;
      new_short = gold_val;
      stop_now  = ($signed({short_ff[37], short_ff}) < $signed({6'b0, thr_ff}))
                  || (count_ff == CW'(MAX_STEPS - 1));

      case (state_ff)
         gsm_pkg::C_IDLE: begin
            if (req_tvalid) begin
               left_in     = gsm_pkg::clamp_pos($signed({req_tdata[36], req_tdata[36:0]}));
               right_in    = gsm_pkg::clamp_pos($signed({req_tdata[73], req_tdata[73:37]}));
               launched_in = 1'b0;
               state_in    = gsm_pkg::C_LONG;
            end
         end
         gsm_pkg::C_LONG: begin
            top_req.start = !launched_ff;
            launched_in   = 1'b1;
            if (mul_rsp.done) begin
               long_in     = gold_val;
               launched_in = 1'b0;
               state_in    = gsm_pkg::C_SHORT;
            end
         end
         gsm_pkg::C_SHORT: begin
            top_req.start = !launched_ff;
            launched_in   = 1'b1;
            if (mul_rsp.done) begin
               short_in    = gold_val;
               launched_in = 1'b0;
               state_in    = gsm_pkg::C_EVAL_RIGHT;
            end
         end
         gsm_pkg::C_EVAL_RIGHT: begin
            obj_x       = left_ff + long_ff;
            obj_start   = !launched_ff;
            launched_in = 1'b1;
            if (obj_rsp.done) begin
               ir_in       = obj_x;
               vr_in       = obj_rsp.value;
               launched_in = 1'b0;
               state_in    = gsm_pkg::C_EVAL_LEFT;
            end
         end
         gsm_pkg::C_EVAL_LEFT: begin
            obj_x       = left_ff + short_ff;
            obj_start   = !launched_ff;
            launched_in = 1'b1;
            if (obj_rsp.done) begin
               il_in       = obj_x;
               vl_in       = obj_rsp.value;
               launched_in = 1'b0;
               count_in    = CW'(1);
               state_in    = gsm_pkg::C_STEP_MUL;
            end
         end
         gsm_pkg::C_STEP_MUL: begin
            top_req.start = !launched_ff;
            launched_in   = 1'b1;
            if (mul_rsp.done) begin
               launched_in = 1'b0;
               long_in     = short_ff;
               short_in    = new_short;
               if (vl_ff < vr_ff) begin
                  // keep left end, old left point moves right
                  right_in     = ir_ff;
                  ir_in        = il_ff;
                  vr_in        = vl_ff;
                  il_in        = left_ff + new_short;
                  take_left_in = 1'b1;
               end else begin
                  left_in      = il_ff;
                  il_in        = ir_ff;
                  vl_in        = vr_ff;
                  ir_in        = il_ff + short_ff;
                  take_left_in = 1'b0;
               end
               state_in = gsm_pkg::C_STEP_EVAL;
            end
         end
         gsm_pkg::C_STEP_EVAL: begin
            obj_x       = take_left_ff ? il_ff : ir_ff;
            obj_start   = !launched_ff;
            launched_in = 1'b1;
            if (obj_rsp.done) begin
               launched_in = 1'b0;
               if (take_left_ff) begin
                  vl_in = obj_rsp.value;
               end else begin
                  vr_in = obj_rsp.value;
               end
               if (stop_now) begin
                  state_in = gsm_pkg::C_DONE;
               end else begin
                  count_in = count_ff + CW'(1);
                  state_in = gsm_pkg::C_STEP_MUL;
               end
            end
         end
         gsm_pkg::C_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {vr_ff, vl_ff, right_ff[36:0], ir_ff[36:0],
                               il_ff[36:0], left_ff[36:0]};
               rsp_valid_in = 1'b1;
               state_in     = gsm_pkg::C_IDLE;
            end
         end
         default: state_in = gsm_pkg::C_IDLE;
      endcase
   end

   assign req_tready = (state_ff == gsm_pkg::C_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: src/gsm_mulshr.sv
`default_nettype none
// (a*b + 2^(sh-1)) >> sh on 64-bit operands, four 32x32 partial products
module gsm_mulshr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gsm_pkg::mul_req_type req,
   output gsm_pkg::mul_rsp_type      rsp
);

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   gsm_pkg::shift_type sh_ff, sh_in;
   logic [2:0]   phase_ff, phase_in;
   logic         busy_ff, busy_in;
   logic [63:0]  prod_ff, prod_in;
   logic [1:0]   pidx_ff, pidx_in;
   logic         pval_ff, pval_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  res_ff, res_in;
   logic         done_ff, done_in;
   logic [31:0]  a_half, b_half;
   logic [6:0]   sh_amt;
   logic [127:0] rounded;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pval_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         pval_ff  <= pval_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      sh_ff   <= sh_in;
      prod_ff <= prod_in;
      pidx_ff <= pidx_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      sh_in    = sh_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      pval_in  = 1'b0;
      pidx_in  = phase_ff[1:0];
      a_half   = phase_ff[0] ? a_ff[63:32] : a_ff[31:0];
      b_half   = phase_ff[1] ? b_ff[63:32] : b_ff[31:0];
      prod_in  = a_half * b_half;
      sh_amt   = ({6'b0, pidx_ff[0]} + {6'b0, pidx_ff[1]}) << 5;
      case (sh_ff)
         gsm_pkg::SH_GOLD:   rounded = (acc_ff + (128'd1 << 31)) >> 32;
         gsm_pkg::SH_TAYLOR: rounded = (acc_ff + (128'd1 << 59)) >> 60;
         gsm_pkg::SH_SQUARE: rounded = (acc_ff + (128'd1 << 30)) >> 31;
         default:            rounded = '0;
      endcase
      if (!busy_ff) begin
         if (req.start) begin
            a_in     = req.a;
            b_in     = req.b;
            sh_in    = req.sh;
            acc_in   = '0;
            phase_in = '0;
            busy_in  = 1'b1;
         end
      end else begin
         if (phase_ff < 3'd4) begin
            pval_in = 1'b1;
         end
         if (pval_ff) begin
            acc_in = acc_ff + ({64'b0, prod_ff} << sh_amt);
         end
         if (phase_ff == 3'd5) begin
            res_in  = rounded[63:0];
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            phase_in = phase_ff + 3'd1;
         end
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule
`default_nettype wire

// File: src/gsm_div.sv
`default_nettype none
// 64-bit by 5-bit unsigned divide, eight quotient bits per cycle
module gsm_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [4:0]  divisor,
   output logic             done,
   output logic [63:0]      quotient
);

   logic [63:0] q_ff, q_in;
   logic [4:0]  rem_ff, rem_in;
   logic [4:0]  d_ff, d_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  t;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      t       = '0;
      if (!busy_ff) begin
         if (start) begin
            q_in    = dividend;
            d_in    = divisor;
            rem_in  = '0;
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else begin
         for (int i = 0; i < 8; i++) begin
            t    = {rem_in, q_in[63]};
            q_in = q_in << 1;
            if (t >= {1'b0, d_ff}) begin
               rem_in  = 5'(t - {1'b0, d_ff});
               q_in[0] = 1'b1;
            end else begin
               rem_in = t[4:0];
            end
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

// File: src/gsm_obj.sv
`default_nettype none
// g(x) = exp(x) - 2x^2, Q.32, saturated to +-2^44
module gsm_obj (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [37:0]   x,
   output logic                      busy,
   output gsm_pkg::obj_rsp_type      rsp,
   output gsm_pkg::mul_req_type      mul_req,
   input  wire gsm_pkg::mul_rsp_type mul_rsp
);

   gsm_pkg::obj_state_type state_ff, state_in;
   logic signed [37:0] xc_ff, xc_in;
   logic [66:0]        r_ff, r_in;
   logic signed [4:0]  k_ff, k_in;
   logic [63:0]        term_ff, term_in, sum_ff, sum_in;
   logic [4:0]         j_ff, j_in;
   logic [47:0]        e_ff, e_in;
   logic               launched_ff, launched_in;
   logic signed [45:0] value_ff, value_in;
   logic               done_ff, done_in;
   logic               div_start, div_done;
   logic [63:0]        div_q;
   logic signed [37:0] xcl;
   logic signed [66:0] xs;
   logic [5:0]         s;
   logic [63:0]        e_full;
   logic signed [48:0] diff;

   gsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (term_ff),
      .divisor  (j_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= gsm_pkg::O_IDLE;
         launched_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
         done_ff     <= done_in;
      end
      xc_ff    <= xc_in;
      r_ff     <= r_in;
      k_ff     <= k_in;
      term_ff  <= term_in;
      sum_ff   <= sum_in;
      j_ff     <= j_in;
      e_ff     <= e_in;
      value_ff <= value_in;
   end

   always_comb begin
      state_in    = state_ff;
      xc_in       = xc_ff;
      r_in        = r_ff;
      k_in        = k_ff;
      term_in     = term_ff;
      sum_in      = sum_ff;
      j_in        = j_ff;
      e_in        = e_ff;
      launched_in = launched_ff;
      value_in    = value_ff;
      done_in     = 1'b0;
      div_start   = 1'b0;
      mul_req     = '0;
      mul_req.sh  = gsm_pkg::SH_TAYLOR;
      xcl         = gsm_pkg::clamp_pos(x);
      xs          = 67'(xcl) <<< 28;
      s           = 6'd28 - 6'(k_ff);
      e_full      = (sum_ff + (64'd1 << (s - 6'd1))) >> s;
      diff        = $signed({1'b0, e_ff}) - $signed({1'b0, mul_rsp.result[47:0]});
      case (state_ff)
         gsm_pkg::O_IDLE: begin
            if (start) begin
               // r starts 13 ln2 high so it is positive; walk k up to floor
               xc_in    = xcl;
               r_in     = $unsigned(xs) + gsm_pkg::K_BIAS;
               k_in     = gsm_pkg::K_START;
               state_in = gsm_pkg::O_REDUCE;
            end
         end
         gsm_pkg::O_REDUCE: begin
            if (r_ff >= {3'b000, gsm_pkg::LN2_Q60}) begin
               r_in = r_ff - {3'b000, gsm_pkg::LN2_Q60};
               k_in = k_ff + 5'sd1;
            end else begin
               term_in  = gsm_pkg::ONE_Q60;
               sum_in   = gsm_pkg::ONE_Q60;
               j_in     = 5'd1;
               state_in = gsm_pkg::O_TERM_MUL;
            end
         end
         gsm_pkg::O_TERM_MUL: begin
            mul_req.start = !launched_ff;
            mul_req.a     = term_ff;
            mul_req.b     = r_ff[63:0];
            mul_req.sh    = gsm_pkg::SH_TAYLOR;
            launched_in   = 1'b1;
            if (mul_rsp.done) begin
               term_in     = mul_rsp.result;
               launched_in = 1'b0;
               state_in    = gsm_pkg::O_TERM_DIV;
            end
         end
         gsm_pkg::O_TERM_DIV: begin
            div_start   = !launched_ff;
            launched_in = 1'b1;
            if (div_done) begin
               term_in     = div_q;
               sum_in      = sum_ff + div_q;
               launched_in = 1'b0;
               if (j_ff == gsm_pkg::EXP_TERMS) begin
                  state_in = gsm_pkg::O_SCALE;
               end else begin
                  j_in     = j_ff + 5'd1;
                  state_in = gsm_pkg::O_TERM_MUL;
               end
            end
         end
         gsm_pkg::O_SCALE: begin
            e_in     = e_full[47:0];
            state_in = gsm_pkg::O_SQUARE;
         end
         gsm_pkg::O_SQUARE: begin
            mul_req.start = !launched_ff;
            mul_req.a     = gsm_pkg::mag38(xc_ff);
            mul_req.b     = gsm_pkg::mag38(xc_ff);
            mul_req.sh    = gsm_pkg::SH_SQUARE;
            launched_in   = 1'b1;
            if (mul_rsp.done) begin
               launched_in = 1'b0;
               if (diff > gsm_pkg::VAL_LIMIT) begin
                  value_in = 46'(gsm_pkg::VAL_LIMIT);
               end else if (diff < -gsm_pkg::VAL_LIMIT) begin
                  value_in = 46'(-gsm_pkg::VAL_LIMIT);
               end else begin
                  value_in = 46'(diff);
               end
               done_in  = 1'b1;
               state_in = gsm_pkg::O_IDLE;
            end
         end
         default: state_in = gsm_pkg::O_IDLE;
      endcase
   end

   assign busy      = (state_ff != gsm_pkg::O_IDLE);
   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule
`default_nettype wire

// File: src/gsm_checker.sv
`default_nettype none
module gsm_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [239:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after request transaction");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response without work in flight");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind golden_section_minimizer gsm_checker u_gsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

// Golden-section search results, predicted in Q.32 fixed point
class minimum_scoreboard;
   typedef struct packed {
      logic [45:0] value_right;
      logic [45:0] value_left;
      logic [36:0] bracket_right;
      logic [36:0] inner_right;
      logic [36:0] inner_left;
      logic [36:0] bracket_left;
   } search_result_type;

   localparam longint POS_LIM = 64'sd34359738368;
   localparam longint VAL_LIM = 64'sd17592186044416;
   localparam longint LN2_Q32 = 64'sd2977044472;

   logic [32:0]       stop_threshold;
   int                max_steps;
   search_result_type pending_results[$];
   int                mismatch_count;
   int                result_count;

   function new(int steps);
      max_steps = steps;
      stop_threshold = 33'd17;
      mismatch_count = 0;
      result_count = 0;
   endfunction

   // (a*b) >> sh, half up
   function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = a * b;
      p = p + (128'd1 << (sh - 1));
      return 64'(p >> sh);
   endfunction

   function automatic longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint gold_scale(longint len);
      longint p;
      logic [63:0] m;
      m = len < 0 ? 64'(-len) : 64'(len);
      p = longint'(mul_round(m, 64'd2654435769, 32));
      return len < 0 ? -p : p;
   endfunction

   function automatic longint exp_fixed(longint x);
      longint k;
      logic [63:0] r, sum, term;
      int s;
      x = clamp(x, POS_LIM);
      k = x / LN2_Q32;
      if (x < 0 && k * LN2_Q32 != x) k--;
      r = (64'(x) << 28) - 64'(k) * 64'h0B17217F7D1CF79B;
      if (r[63]) begin
         k--;
         r = r + 64'h0B17217F7D1CF79B;
      end
      if (r >= 64'h0B17217F7D1CF79B) begin
         k++;
         r = r - 64'h0B17217F7D1CF79B;
      end
      sum = 64'h1000000000000000;
      term = sum;
      for (int j = 1; j <= 20; j++) begin
         term = mul_round(term, r, 60) / 64'(j);
         sum = sum + term;
      end
      s = 28 - int'(k);
      return longint'((sum + (64'd1 << (s - 1))) >> s);
   endfunction

   function automatic longint objective(longint x);
      longint e, sq;
      logic [63:0] ax;
      e = exp_fixed(x);
      x = clamp(x, POS_LIM);
      ax = x < 0 ? 64'(-x) : 64'(x);
      sq = longint'(mul_round(ax, ax, 31));
      return clamp(e - sq, VAL_LIM);
   endfunction

   function automatic search_result_type search(logic [36:0] lo, logic [36:0] hi);
      longint left, right, il, ir, vl, vr, long_len, short_len;
      search_result_type res;
      left = clamp(longint'($signed(lo)), POS_LIM);
      right = clamp(longint'($signed(hi)), POS_LIM);
      long_len = gold_scale(right - left);
      short_len = gold_scale(long_len);
      ir = left + long_len;
      vr = objective(ir);
      il = left + short_len;
      vl = objective(il);
      for (int n = 1; n < max_steps; n++) begin
         long_len = short_len;
         short_len = gold_scale(long_len);
         if (vl < vr) begin
            right = ir;
            ir = il;
            vr = vl;
            il = left + short_len;
            vl = objective(il);
         end else begin
            left = il;
            il = ir;
            vl = vr;
            ir = left + long_len;
            vr = objective(ir);
         end
         if (short_len < longint'({31'b0, stop_threshold})) break;
      end
      res.bracket_left = 37'(left);
      res.inner_left = 37'(il);
      res.inner_right = 37'(ir);
      res.bracket_right = 37'(right);
      res.value_left = 46'(vl);
      res.value_right = 46'(vr);
      return res;
   endfunction

   function void note_interval(logic [79:0] tdata);
      pending_results.push_back(search(tdata[36:0], tdata[73:37]));
   endfunction

   function void check_result(logic [239:0] tdata);
      search_result_type got, exp_res;
      got = tdata;
      result_count++;
      if (pending_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("ERROR: unexpected result %h", tdata);
         return;
      end
      exp_res = pending_results.pop_front();
      if (got !== exp_res) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("ERROR: result %0d mismatch", result_count);
            $display("  bracket exp %h %h got %h %h", exp_res.bracket_left,
               exp_res.bracket_right, got.bracket_left, got.bracket_right);
            $display("  inner   exp %h %h got %h %h", exp_res.inner_left,
               exp_res.inner_right, got.inner_left, got.inner_right);
            $display("  values  exp %h %h got %h %h", exp_res.value_left,
               exp_res.value_right, got.value_left, got.value_right);
         end
      end
   endfunction
endclass

module testbench;
   localparam int MAX_STEPS = 51;
   localparam logic signed [36:0] Q_EIGHT = 37'sd34359738368;
   localparam logic signed [36:0] Q_ONE = 37'sd4294967296;

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   logic [32:0]   csr_wr_data;
   logic          req_tvalid;
   logic          req_tready;
   // [36:0] interval_low, [73:37] interval_high, [79:74] zero
   logic [79:0]   req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   // [36:0] bracket_left, [73:37] inner_left, [110:74] inner_right,
   // [147:111] bracket_right, [193:148] value_left, [239:194] value_right
   logic [239:0]  rsp_tdata;

   minimum_scoreboard search_board;
   bit            idling_on;   // random gaps on both sides
   int            interval_count;

   golden_section_minimizer #(.MAX_STEPS(MAX_STEPS)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: monitor plus random backpressure bursts
   initial begin
      int hold;
      rsp_tready = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) search_board.check_result(rsp_tdata);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            hold = $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One search interval; tvalid stays high after the transaction and drops
   // only for an idle gap, a threshold write or the end of the stimulus
   task automatic send_interval(logic [36:0] lo, logic [36:0] hi);
      if (idling_on && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, hi, lo};
      do @(posedge clock); while (!req_tready);
      search_board.note_interval({6'b0, hi, lo});
      interval_count++;
   endtask

   // Threshold writes only with the block drained
   task automatic write_threshold(logic [32:0] thr);
      req_tvalid <= 1'b0;
      while (search_board.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= thr;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      search_board.stop_threshold = thr;
   endtask

   function automatic logic [36:0] random_point();
      case ($urandom_range(0, 4))
         0: return 37'({$urandom, $urandom});          // full field, may saturate
         1: return Q_EIGHT;
         2: return -Q_EIGHT;
         default: return 37'(longint'($urandom_range(0, 32'hFFFFFFFF)) * 8
                        - 64'sd17179869184 + longint'($urandom_range(0, 32'hFFFFFFFF)));
      endcase
   endfunction

   task automatic random_phase(int count);
      logic [36:0] lo, hi, t;
      for (int n = 0; n < count; n++) begin
         lo = random_point();
         hi = random_point();
         // mostly ordered intervals; a few reversed ones remain
         if ($urandom_range(0, 9) != 0 && $signed(lo) > $signed(hi)) begin
            t = lo;
            lo = hi;
            hi = t;
         end
         send_interval(lo, hi);
      end
   endtask

   initial begin
      int wait_cycles;
      search_board = new(MAX_STEPS);
      idling_on = 1'b1;
      interval_count = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, reversed, empty and saturating intervals
      send_interval(-Q_EIGHT, Q_EIGHT);
      send_interval(37'sd0, Q_ONE);
      send_interval(Q_EIGHT, -Q_EIGHT);                 // reversed
      send_interval(Q_ONE, Q_ONE);                       // zero length
      send_interval(37'h10_0000_0000, 37'h0F_FFFF_FFFF); // both beyond range
      send_interval(37'h1F_FFFF_FFFF, 37'h00_0000_0001);
      send_interval(-Q_ONE, 37'sd0);
      send_interval(37'sd3 * Q_ONE, 37'sd5 * Q_ONE);
      write_threshold(33'd0);                            // run all steps
      send_interval(-Q_EIGHT, Q_EIGHT);
      send_interval(37'sd0, 37'sd2 * Q_ONE);
      send_interval(Q_ONE, -Q_ONE);
      write_threshold(33'h1_0000_0000);                  // large: stops early
      send_interval(-Q_EIGHT, Q_EIGHT);
      send_interval(-Q_ONE, Q_ONE);
      write_threshold(33'h1_FFFF_FFFF);
      send_interval(-Q_EIGHT, Q_EIGHT);

      // random: mid thresholds mostly, keep runs short
      write_threshold(33'h0010_0000);
      random_phase(90);
      write_threshold(33'($urandom_range(17, 32'h0400_0000)));
      random_phase(90);
      write_threshold(33'd17);
      random_phase(60);
      idling_on = 1'b0;
      random_phase(50);
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (search_board.pending_results.size() != 0 && wait_cycles < 2000000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      $display("Ran %0d search intervals, %0d results checked, thresholds 0 to max.",
         interval_count, search_board.result_count);
      if (search_board.mismatch_count == 0 && search_board.pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Timeout for the worst-case search of all 304 intervals plus stalls
   initial begin
      #500ms;
      $display("simulation failed");
      $finish;
   end
endmodule

// File: files.f
src/gsm_pkg.sv
src/gsm_mulshr.sv
src/gsm_div.sv
src/gsm_obj.sv
src/golden_section_minimizer.sv
src/gsm_checker.sv
test/testbench.sv
